[sv/i2cms_pkg.sv]
// shared types and codes for the i2c master transfer sequencer
// no dependencies; imported by the top level, i2cms_ctrl and i2cms_chk
`timescale 1ns / 1ps

package i2cms_pkg;

	typedef enum logic [2:0] {
		FUNC_LOAD   = 3'd0,
		FUNC_WRITE  = 3'd1,
		FUNC_READ   = 3'd2,
		FUNC_STATUS = 3'd3,
		FUNC_FETCH  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_RESET = 3'd1,
		CMD_START = 3'd2,
		CMD_STOP  = 3'd3,
		CMD_ACK   = 3'd4,
		CMD_NACK  = 3'd5
	} cmd_t;

	localparam logic [7:0] STATUS_MASK    = 8'hF8;
	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_RSTART      = 8'h10;
	localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
	localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
	localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
	localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
	localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

	// what the output stage needs to build a result
	typedef struct packed {
		cmd_t cmd;
		logic txv;
		logic use_rd;
		logic fetch;
	} item_ctl_t;

	typedef struct packed {
		logic       we;
		logic       re;
		logic [7:0] wdata;
	} mem_req_t;

endpackage

[sv/i2c_master_transfer_sequencer.sv]
// I2C master transfer sequencer. One request is accepted per clock while in_stall is low. The
// byte store read and the request's control are registered at the accepting edge; the output
// register loads from them when stage 1 advances and so presents the result. A held result
// stalls the input only once the request behind it is also waiting.
// Each request makes at most one access to the byte store, a ram with a registered read, so
// a read always sees a write made by an earlier request. Position and transfer length live in
// flip-flops and update at acceptance. Store entries never loaded read back as unknown.
// depends on i2cms_pkg, i2cms_ram, i2cms_ctrl
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer
	import i2cms_pkg::*;
#(
	parameter int STORE_DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] func,
	input  logic [6:0] slave_addr,
	input  logic [6:0] byte_count,
	input  logic [6:0] byte_index,
	input  logic [7:0] load_byte,
	input  logic [7:0] status_code,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] bus_command,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic [7:0] fetched_byte
);

	localparam int AW = $clog2(STORE_DEPTH);

	logic           take;
	logic           adv;
	mem_req_t       mem_req;
	logic [AW-1:0]  mem_addr;
	item_ctl_t      ctl;
	item_ctl_t      ctl_s1;
	logic           valid_s1;
	logic [7:0]     rd_data;
	logic           out_valid_q;
	cmd_t           cmd_q;
	logic           txv_q;
	logic [7:0]     txb_q;
	logic [7:0]     fb_q;

	// stage 1 moves on unless a held result blocks the output register
	assign adv      = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;

	i2cms_ctrl #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.func       (func),
		.slave_addr (slave_addr),
		.byte_count (byte_count),
		.byte_index (byte_index),
		.load_byte  (load_byte),
		.status_code(status_code),
		.rx_byte    (rx_byte),
		.mem_req    (mem_req),
		.mem_addr   (mem_addr),
		.ctl        (ctl)
	);

	i2cms_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_addr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1 <= ctl;
		end
		if (adv) begin
			cmd_q <= ctl_s1.cmd;
			txv_q <= ctl_s1.txv;
			txb_q <= (ctl_s1.txv && ctl_s1.use_rd) ? rd_data : 8'd0;
			fb_q  <= (ctl_s1.fetch && ctl_s1.use_rd) ? rd_data : 8'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign bus_command  = cmd_q;
	assign tx_valid     = txv_q;
	assign tx_byte      = txb_q;
	assign fetched_byte = fb_q;

endmodule

[sv/i2cms_ram.sv]
// generic ram with separate write and read addresses, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module i2cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/i2cms_ctrl.sv]
// request decoder: position and length registers, byte store access and command choice
// depends on i2cms_pkg
`timescale 1ns / 1ps

module i2cms_ctrl
	import i2cms_pkg::*;
#(
	parameter int STORE_DEPTH = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic [2:0]                     func,
	input  logic [6:0]                     slave_addr,
	input  logic [6:0]                     byte_count,
	input  logic [6:0]                     byte_index,
	input  logic [7:0]                     load_byte,
	input  logic [7:0]                     status_code,
	input  logic [7:0]                     rx_byte,
	output mem_req_t                       mem_req,
	output logic [$clog2(STORE_DEPTH)-1:0] mem_addr,
	output item_ctl_t                      ctl
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);

	logic [7:0] pos_q, pos_d;
	logic [7:0] tlen_q, tlen_d;
	logic [7:0] st;
	logic [8:0] idx;
	logic [7:0] p;
	logic [7:0] pos_inc;

	assign st      = status_code & STATUS_MASK;
	assign idx     = {2'b00, byte_index} + 9'd1;
	assign pos_inc = pos_q + 8'd1;
	// a start or repeated start rewinds to the address byte
	assign p       = (st == ST_START || st == ST_RSTART) ? 8'd0 : pos_q;

	always_comb begin
		mem_req  = '0;
		mem_addr = '0;
		ctl      = '{cmd: CMD_NONE, txv: 1'b0, use_rd: 1'b0, fetch: 1'b0};
		pos_d    = pos_q;
		tlen_d   = tlen_q;
		unique case (func_t'(func))
			FUNC_LOAD: begin
				mem_req.we    = (idx < DEPTH9);
				mem_req.wdata = load_byte;
				mem_addr      = idx[AW-1:0];
			end
			FUNC_WRITE, FUNC_READ: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = {slave_addr, (func_t'(func) == FUNC_READ)};
				tlen_d        = {1'b0, byte_count} + 8'd1;
				ctl.cmd       = CMD_START;
			end
			FUNC_STATUS: begin
				unique case (st) inside
					ST_START, ST_RSTART, ST_SLA_W_ACK, ST_DATA_W_ACK: begin
						pos_d = p;
						if (p < tlen_q) begin
							ctl.txv    = 1'b1;
							mem_req.re = ({1'b0, p} < DEPTH9);
							ctl.use_rd = ({1'b0, p} < DEPTH9);
							mem_addr   = p[AW-1:0];
							pos_d      = p + 8'd1;
							ctl.cmd    = CMD_NACK;
						end else begin
							ctl.cmd = CMD_STOP;
						end
					end
					ST_DATA_R_ACK: begin
						mem_req.we    = ({1'b0, pos_q} < DEPTH9);
						mem_req.wdata = rx_byte;
						mem_addr      = pos_q[AW-1:0];
						pos_d         = pos_inc;
						ctl.cmd       = (({1'b0, pos_inc} + 9'd1) < {1'b0, tlen_q})
						                ? CMD_ACK : CMD_NACK;
					end
					ST_SLA_R_ACK: begin
						ctl.cmd = (({1'b0, pos_q} + 9'd1) < {1'b0, tlen_q})
						          ? CMD_ACK : CMD_NACK;
					end
					ST_DATA_R_NACK: begin
						mem_req.we    = ({1'b0, pos_q} < DEPTH9);
						mem_req.wdata = rx_byte;
						mem_addr      = pos_q[AW-1:0];
						ctl.cmd       = CMD_STOP;
					end
					default: begin
						ctl.cmd = CMD_RESET;
					end
				endcase
			end
			FUNC_FETCH: begin
				mem_req.re = (idx < DEPTH9);
				ctl.use_rd = (idx < DEPTH9);
				ctl.fetch  = 1'b1;
				mem_addr   = idx[AW-1:0];
			end
			default: begin
			end
		endcase
		if (!take) begin
			mem_req.we = 1'b0;
			mem_req.re = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tlen_q <= '0;
		end else if (take) begin
			pos_q  <= pos_d;
			tlen_q <= tlen_d;
		end
	end

endmodule

[sv/i2cms_chk.sv]
// port-level checks for the i2c master transfer sequencer, bound to the top level
// depends on i2cms_pkg and i2c_master_transfer_sequencer
`timescale 1ns / 1ps

module i2cms_chk
	import i2cms_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] bus_command,
	input logic       tx_valid,
	input logic [7:0] tx_byte,
	input logic [7:0] fetched_byte
);

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bus_command) && $stable(tx_valid)
			&& $stable(tx_byte) && $stable(fetched_byte))
		else $error("held result changed");

	// a byte to send always goes with continue without ack
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid |-> bus_command == CMD_NACK)
		else $error("tx byte without matching command");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == 8'd0)
		else $error("tx byte set without tx_valid");

	// fetched data only on a result that carries no bus action
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fetched_byte != 8'd0 |-> bus_command == CMD_NONE && !tx_valid)
		else $error("fetched byte on a bus result");

endmodule

bind i2c_master_transfer_sequencer i2cms_chk u_chk (.*);
